/* design/rsst_pkg.sv */
// shared constants and codes for the range sum segment tree
package rsst_pkg;

   localparam int LEAVES_DEFAULT = 1024;
   localparam int INDEX_W        = 10;
   localparam int VALUE_W        = 32;
   localparam int SUM_W          = 42;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

endpackage

/* design/range_sum_segment_tree_top.sv */
// range sum segment tree: node memory sequencer for point writes and range queries
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | op, leaf_index, leaf_value, range_low, range_high
//   rsp     | out       | rsp_valid/rsp_ready  | range_sum (query items only)
//
// a write item does one leaf write, then walks the ancestor levels up to the root,
//   each level reading the sibling and writing the parent
// a query item walks the tree levels of its range, two node reads per level
//   through the two memory read ports; an empty range skips the walk and returns zero
// after reset a clearing pass zeroes the 2*LEAVES nodes, one per cycle, with req_ready low
// a finished result waits in the output register; the next item is taken meanwhile,
//   and a query only stalls in its last cycle while that register is still full
module range_sum_segment_tree_top #(
   parameter int LEAVES = rsst_pkg::LEAVES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [rsst_pkg::INDEX_W-1:0]         req_leaf_index,
   input  logic signed [rsst_pkg::VALUE_W-1:0]  req_leaf_value,
   input  logic [rsst_pkg::INDEX_W-1:0]         req_range_low,
   input  logic [rsst_pkg::INDEX_W-1:0]         req_range_high,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rsst_pkg::SUM_W-1:0]    rsp_range_sum
);
   import rsst_pkg::*;

   localparam int AW = $clog2(2 * LEAVES);
   localparam int IW = AW + 1;
   localparam int CW = (IW > INDEX_W) ? IW : INDEX_W;
   localparam logic [CW-1:0] LEAVES_C  = CW'(LEAVES);
   localparam logic [AW-1:0] CLR_LAST  = AW'(2 * LEAVES - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WRITE = 3'd2;
   localparam logic [2:0] ST_QUERY = 3'd3;
   localparam logic [2:0] ST_QDONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [SUM_W-1:0] cur_ff, cur_in;
   logic [IW-1:0]    l_ff, l_in;
   logic [IW-1:0]    r_ff, r_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic             pend_ff, pend_in;
   logic             take_a_ff, take_a_in;
   logic             take_b_ff, take_b_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [SUM_W-1:0] mem_wdata;
   logic [AW-1:0]    mem_raddr_a;
   logic [AW-1:0]    mem_raddr_b;
   logic [SUM_W-1:0] mem_rdata_a;
   logic [SUM_W-1:0] mem_rdata_b;

   logic [CW-1:0]    lo_ext, hi_ext, hi_clamp, idx_ext;
   logic             q_empty;
   logic             w_ok;
   logic [AW-1:0]    w_pos;
   logic [AW-1:0]    parent;
   logic [SUM_W-1:0] leaf_sext;
   logic [SUM_W-1:0] add_a, add_b;
   logic             accept;
   logic             rsp_free;

   rsst_node_ram #(
      .DEPTH (2 * LEAVES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .raddr_a (mem_raddr_a),
      .raddr_b (mem_raddr_b),
      .rdata_a (mem_rdata_a),
      .rdata_b (mem_rdata_b)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign accept        = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;
   assign rsp_free      = !rsp_valid_ff || rsp_ready;

   assign lo_ext    = CW'(req_range_low);
   assign hi_ext    = CW'(req_range_high);
   assign idx_ext   = CW'(req_leaf_index);
   assign hi_clamp  = (hi_ext >= LEAVES_C) ? (LEAVES_C - CW'(1)) : hi_ext;
   assign q_empty   = lo_ext > hi_clamp;
   assign w_ok      = idx_ext < LEAVES_C;
   assign w_pos     = AW'(idx_ext + LEAVES_C);
   assign parent    = pos_ff >> 1;
   assign leaf_sext = {{(SUM_W - VALUE_W){req_leaf_value[VALUE_W-1]}}, req_leaf_value};
   assign add_a     = take_a_ff ? mem_rdata_a : '0;
   assign add_b     = take_b_ff ? mem_rdata_b : '0;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      acc_in       = pend_ff ? (acc_ff + add_a + add_b) : acc_ff;
      pend_in      = 1'b0;
      take_a_in    = l_ff[0];
      take_b_in    = r_ff[0];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sum_in   = rsp_sum_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = cur_ff;
      mem_raddr_a  = AW'(l_ff);
      mem_raddr_b  = AW'(r_ff - IW'(1));

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_QUERY) begin
                  acc_in = '0;
                  l_in   = IW'(lo_ext + LEAVES_C);
                  r_in   = IW'(hi_clamp + LEAVES_C + CW'(1));
                  state_in = q_empty ? ST_QDONE : ST_QUERY;
               end else if (w_ok) begin
                  mem_we      = 1'b1;
                  mem_waddr   = w_pos;
                  mem_wdata   = leaf_sext;
                  mem_raddr_a = w_pos ^ AW'(1);
                  pos_in      = w_pos;
                  cur_in      = leaf_sext;
                  state_in    = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            mem_we      = 1'b1;
            mem_waddr   = parent;
            mem_wdata   = cur_ff + mem_rdata_a;
            mem_raddr_a = parent ^ AW'(1);
            cur_in      = cur_ff + mem_rdata_a;
            pos_in      = parent;
            if (parent == AW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (l_ff < r_ff) begin
               pend_in = 1'b1;
               l_in    = (l_ff + IW'(l_ff[0])) >> 1;
               r_in    = (r_ff - IW'(r_ff[0])) >> 1;
            end else begin
               state_in = ST_QDONE;
            end
         end
         ST_QDONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      cur_ff     <= cur_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      acc_ff     <= acc_in;
      take_a_ff  <= take_a_in;
      take_b_ff  <= take_b_in;
      rsp_sum_ff <= rsp_sum_in;
   end

endmodule

/* design/rsst_node_ram.sv */
// node sum memory: one write port, two registered read ports
module rsst_node_ram #(
   parameter int DEPTH = 2 * rsst_pkg::LEAVES_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [AW-1:0]               waddr,
   input  logic [rsst_pkg::SUM_W-1:0]  wdata,
   input  logic [AW-1:0]               raddr_a,
   input  logic [AW-1:0]               raddr_b,
   output logic [rsst_pkg::SUM_W-1:0]  rdata_a,
   output logic [rsst_pkg::SUM_W-1:0]  rdata_b
);
   import rsst_pkg::*;

   logic [SUM_W-1:0] mem [DEPTH];
   logic [SUM_W-1:0] rdata_a_ff;
   logic [SUM_W-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

/* design/rsst_checker.sv */
// port-level checks for the range sum segment tree, bound to the top level
module rsst_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_op,
   input logic [rsst_pkg::INDEX_W-1:0]         req_leaf_index,
   input logic signed [rsst_pkg::VALUE_W-1:0]  req_leaf_value,
   input logic [rsst_pkg::INDEX_W-1:0]         req_range_low,
   input logic [rsst_pkg::INDEX_W-1:0]         req_range_high,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [rsst_pkg::SUM_W-1:0]    rsp_range_sum
);
   import rsst_pkg::*;

   // clearing pass holds off items right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_range_sum))
      else $error("stalled result item changed or dropped");

   // a write item never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("result item after a write item");

   // results only appear when the block is busy finishing a query
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result item appeared without a query in flight");

   a_empty_range_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_QUERY && req_range_low > req_range_high
         && !rsp_valid |=> ##1 (rsp_valid && rsp_range_sum == '0))
      else $error("empty range query did not return zero");

endmodule

bind range_sum_segment_tree_top rsst_checker u_rsst_checker (.*);

/* test/range_sum_segment_tree_top_tb.sv */
// self-checking testbench for the range sum segment tree: point writes and range queries
`timescale 1ns / 100ps

module range_sum_segment_tree_top_tb;
   import rsst_pkg::*;

   localparam int LEAVES       = LEAVES_DEFAULT;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 30;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_op;
   logic [INDEX_W-1:0]         req_leaf_index;
   logic signed [VALUE_W-1:0]  req_leaf_value;
   logic [INDEX_W-1:0]         req_range_low;
   logic [INDEX_W-1:0]         req_range_high;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SUM_W-1:0]    rsp_range_sum;

   logic signed [VALUE_W-1:0]  leaf_vals [LEAVES];
   logic signed [SUM_W-1:0]    pending_sums [$];
   int                         error_count = 0;
   int unsigned                cycle_count = 0;
   bit                         no_idle = 1'b0;
   bit                         rsp_hold_request = 1'b0;

   range_sum_segment_tree_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_leaf_index (req_leaf_index),
      .req_leaf_value (req_leaf_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_range_sum  (rsp_range_sum)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [SUM_W-1:0] range_total(logic [INDEX_W-1:0] lo,
                                                            logic [INDEX_W-1:0] hi);
      logic signed [SUM_W-1:0] acc;
      int                      top;
      acc = '0;
      top = int'(hi);
      if (top > LEAVES - 1) top = LEAVES - 1;
      for (int i = int'(lo); i <= top; i++) acc = acc + SUM_W'(leaf_vals[INDEX_W'(i)]);
      return acc;
   endfunction

   task automatic send_item(logic op, int idx, logic signed [VALUE_W-1:0] val,
                            int lo, int hi);
      int                 gap;
      logic [INDEX_W-1:0] idx_b;
      logic [INDEX_W-1:0] lo_b;
      logic [INDEX_W-1:0] hi_b;
      idx_b = INDEX_W'(idx);
      lo_b  = INDEX_W'(lo);
      hi_b  = INDEX_W'(hi);
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op         <= op;
      req_leaf_index <= idx_b;
      req_leaf_value <= val;
      req_range_low  <= lo_b;
      req_range_high <= hi_b;
      req_valid      <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (op == OP_WRITE) begin
         if (idx_b < LEAVES) leaf_vals[idx_b] = val;
      end else begin
         pending_sums.push_back(range_total(lo_b, hi_b));
      end
   endtask

   task automatic write_leaf(int idx, logic signed [VALUE_W-1:0] val);
      send_item(OP_WRITE, idx, val, int'($urandom), int'($urandom));
   endtask

   task automatic query_range(int lo, int hi);
      send_item(OP_QUERY, int'($urandom), VALUE_W'($urandom), lo, hi);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_sums.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic test_directed();
      query_range(0, LEAVES - 1);
      write_leaf(0, VALUE_MAX);
      write_leaf(LEAVES - 1, VALUE_MIN);
      write_leaf(512, -1);
      write_leaf(511, 1);
      send_item(OP_WRITE, 7, 32'sd12345, '1, '1);
      query_range(0, LEAVES - 1);
      query_range(0, 0);
      query_range(LEAVES - 1, LEAVES - 1);
      query_range(511, 512);
      query_range(600, 100);
      query_range(LEAVES - 1, 0);
      query_range(5, 5);
      send_item(OP_QUERY, '1, VALUE_MIN, 0, 7);
      send_item(OP_QUERY, '1, VALUE_MAX, 1, 1);
      write_leaf(0, VALUE_MIN);
      write_leaf(LEAVES - 1, VALUE_MAX);
      write_leaf(7, 0);
      query_range(0, LEAVES - 1);
      query_range(1, LEAVES - 2);
      wait_for_results();
   endtask

   // receiver stops for a long stretch while queries and writes keep coming
   task automatic test_backpressure();
      int lo;
      int hi;
      rsp_hold_request = 1'b1;
      no_idle = 1'b1;
      for (int i = 0; i < 24; i++) begin
         lo = $urandom_range(0, LEAVES - 1);
         hi = $urandom_range(lo, LEAVES - 1);
         if (i % 4 == 3) write_leaf($urandom_range(0, LEAVES - 1), $urandom);
         else query_range(lo, hi);
      end
      no_idle = 1'b0;
      wait_for_results();
   endtask

   // fill every leaf with one extreme value to reach an end of the sum range
   task automatic test_full_scale(logic signed [VALUE_W-1:0] val, bit busy);
      int lo;
      no_idle = busy;
      for (int i = 0; i < LEAVES; i++) begin
         write_leaf(i, val);
         if (i % 128 == 127) begin
            lo = $urandom_range(0, LEAVES - 1);
            query_range(lo, $urandom_range(lo, LEAVES - 1));
         end
      end
      query_range(0, LEAVES - 1);
      no_idle = 1'b0;
      wait_for_results();
   endtask

   function automatic int pick_index();
      if ($urandom_range(0, 4) == 0) begin
         return $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(1008, 1023);
      end
      return $urandom_range(0, LEAVES - 1);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return VALUE_MAX;
      if (r < 8) return VALUE_MIN;
      if (r < 12) return -1;
      if (r < 15) return 0;
      if (r < 35) return $urandom_range(0, 200) - 100;
      return $urandom;
   endfunction

   task automatic test_random_mix(int count);
      int kind;
      int lo;
      int hi;
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (i % 400 == 399) wait_for_results();
         if ($urandom_range(0, 1) == 0) begin
            write_leaf(pick_index(), pick_value());
         end else begin
            kind = $urandom_range(0, 99);
            lo = $urandom_range(0, LEAVES - 1);
            hi = $urandom_range(0, LEAVES - 1);
            if (kind < 10) begin
               lo = $urandom_range(1, LEAVES - 1);
               hi = $urandom_range(0, lo - 1);
            end else if (kind < 20) begin
               hi = lo;
            end else if (kind < 25) begin
               lo = 0;
            end else if (kind < 30) begin
               hi = LEAVES - 1;
            end else if (lo > hi) begin
               {lo, hi} = {hi, lo};
            end
            query_range(lo, hi);
         end
      end
      no_idle = 1'b0;
      wait_for_results();
   endtask

   initial begin : rsp_side
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = no_idle ? 0 : pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_results
      logic signed [SUM_W-1:0] exp_sum;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_sums.size() == 0) begin
            $display("%0t: unexpected item, expected none, got range_sum %0d",
                     $time, rsp_range_sum);
            error_count++;
         end else begin
            exp_sum = pending_sums.pop_front();
            if (rsp_range_sum !== exp_sum) begin
               $display("%0t: range_sum mismatch, expected %0d, got %0d",
                        $time, exp_sum, rsp_range_sum);
               error_count++;
            end
         end
      end
   end

   initial begin
      foreach (leaf_vals[i]) leaf_vals[i] = '0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= OP_WRITE;
      req_leaf_index <= '0;
      req_leaf_value <= '0;
      req_range_low  <= '0;
      req_range_high <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_full_scale(VALUE_MIN, 1'b1);
      test_random_mix(1000);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/rsst_pkg.sv
design/rsst_node_ram.sv
design/range_sum_segment_tree_top.sv
design/rsst_checker.sv
test/range_sum_segment_tree_top_tb.sv
